// ----- sv/pua_pkg.sv -----
package pua_pkg;

	localparam int DATA_W        = 32;
	localparam int ROWS_W        = 5;
	localparam int BLEND_BITS    = 16;
	localparam int MAX_ROWS_DEF  = 16;
	localparam int FRAC_BITS_DEF = 16;

	// configuration register indexes
	localparam logic REG_DELTA_TIME = 1'b0;
	localparam logic REG_ATLAS_ROWS = 1'b1;

	localparam logic [DATA_W-1:0] DT_RESET   = 32'd1092;
	localparam logic [ROWS_W-1:0] ROWS_RESET = 5'd4;

	localparam logic signed [69:0] SAT_MAX = 70'sd2147483647;
	localparam logic signed [69:0] SAT_MIN = -70'sd2147483648;

	// kinematic results travelling alongside the frame divider
	typedef struct packed {
		logic signed [DATA_W-1:0] pos_x;
		logic signed [DATA_W-1:0] pos_y;
		logic signed [DATA_W-1:0] pos_z;
		logic signed [DATA_W-1:0] vel_x;
		logic signed [DATA_W-1:0] vel_y;
		logic signed [DATA_W-1:0] vel_z;
		logic [DATA_W-1:0]        age;
		logic                     dead;
		logic                     life_zero;
	} kin_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [69:0] v);
		logic signed [69:0] r;
		r = v;
		if (v > SAT_MAX) begin
			r = SAT_MAX;
		end else if (v < SAT_MIN) begin
			r = SAT_MIN;
		end
		return r[DATA_W-1:0];
	endfunction

endpackage

// ----- sv/pua_kin.sv -----
module pua_kin #(
	parameter int FRAC_BITS = pua_pkg::FRAC_BITS_DEF,
	parameter int SW        = 9
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_valid,
	input  logic signed [31:0]       pos_x,
	input  logic signed [31:0]       pos_y,
	input  logic signed [31:0]       pos_z,
	input  logic signed [31:0]       vel_x,
	input  logic signed [31:0]       vel_y,
	input  logic signed [31:0]       vel_z,
	input  logic [31:0]              age,
	input  logic [31:0]              lifespan,
	input  logic signed [31:0]       gravity_factor,
	input  logic [31:0]              dt,
	input  logic [SW-1:0]            stages,
	output logic                     out_valid,
	output pua_pkg::kin_t            out_kin,
	output logic [32+SW-1:0]         out_num,
	output logic [31:0]              out_life
);

	localparam int NW = 32 + SW;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	// s1: captured item
	logic signed [31:0] px_s1, py_s1, pz_s1, vx_s1, vy_s1, vz_s1, g_s1;
	logic [31:0]        age_s1, life_s1;
	// s2: products, new age
	logic signed [63:0] pvx_s2, pvy_s2, pvz_s2, gp_s2;
	logic signed [31:0] px_s2, py_s2, pz_s2, vx_s2, vy_s2, vz_s2;
	logic [31:0]        nage_s2, life_s2;
	// s3: raw sums, frame numerator
	logic signed [64:0] sx_s3, sy_s3, sz_s3;
	logic signed [67:0] gp10_s3;
	logic signed [31:0] vx_s3, vy_s3, vz_s3;
	logic [31:0]        nage_s3, life_s3;
	logic [NW-1:0]      num_s3;
	logic               dead_s3, lz_s3;
	// s4: saturated position, raw vertical velocity
	logic signed [31:0] px_s4, py_s4, pz_s4, vx_s4, vz_s4;
	logic signed [68:0] vyd_s4;
	logic [31:0]        nage_s4, life_s4;
	logic [NW-1:0]      num_s4;
	logic               dead_s4, lz_s4;
	// s5
	pua_pkg::kin_t      kin_s5;
	logic [NW-1:0]      num_s5;
	logic [31:0]        life_s5;

	logic signed [63:0] dt_ext;
	logic [32:0]        age_sum;
	logic [31:0]        nage_c;

	assign dt_ext  = 64'(dt);
	assign age_sum = {1'b0, age_s1} + {1'b0, dt};
	assign nage_c  = age_sum[32] ? '1 : age_sum[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1   <= pos_x;
			py_s1   <= pos_y;
			pz_s1   <= pos_z;
			vx_s1   <= vel_x;
			vy_s1   <= vel_y;
			vz_s1   <= vel_z;
			g_s1    <= gravity_factor;
			age_s1  <= age;
			life_s1 <= lifespan;

			pvx_s2  <= 64'(vx_s1) * dt_ext;
			pvy_s2  <= 64'(vy_s1) * dt_ext;
			pvz_s2  <= 64'(vz_s1) * dt_ext;
			gp_s2   <= 64'(g_s1) * dt_ext;
			px_s2   <= px_s1;
			py_s2   <= py_s1;
			pz_s2   <= pz_s1;
			vx_s2   <= vx_s1;
			vy_s2   <= vy_s1;
			vz_s2   <= vz_s1;
			nage_s2 <= nage_c;
			life_s2 <= life_s1;

			sx_s3   <= 65'(px_s2) + 65'(pvx_s2 >>> FRAC_BITS);
			sy_s3   <= 65'(py_s2) + 65'(pvy_s2 >>> FRAC_BITS);
			sz_s3   <= 65'(pz_s2) + 65'(pvz_s2 >>> FRAC_BITS);
			// 10 * g * dt, exact
			gp10_s3 <= (68'(gp_s2) <<< 3) + (68'(gp_s2) <<< 1);
			num_s3  <= NW'(nage_s2) * NW'(stages);
			dead_s3 <= life_s2 < nage_s2;
			lz_s3   <= life_s2 == '0;
			vx_s3   <= vx_s2;
			vy_s3   <= vy_s2;
			vz_s3   <= vz_s2;
			nage_s3 <= nage_s2;
			life_s3 <= life_s2;

			px_s4   <= pua_pkg::sat32(70'(sx_s3));
			py_s4   <= pua_pkg::sat32(70'(sy_s3));
			pz_s4   <= pua_pkg::sat32(70'(sz_s3));
			vyd_s4  <= 69'(vy_s3) - 69'(gp10_s3 >>> FRAC_BITS);
			vx_s4   <= vx_s3;
			vz_s4   <= vz_s3;
			nage_s4 <= nage_s3;
			life_s4 <= life_s3;
			num_s4  <= num_s3;
			dead_s4 <= dead_s3;
			lz_s4   <= lz_s3;

			kin_s5.pos_x     <= px_s4;
			kin_s5.pos_y     <= py_s4;
			kin_s5.pos_z     <= pz_s4;
			kin_s5.vel_x     <= vx_s4;
			kin_s5.vel_y     <= pua_pkg::sat32(70'(vyd_s4));
			kin_s5.vel_z     <= vz_s4;
			kin_s5.age       <= nage_s4;
			kin_s5.dead      <= dead_s4;
			kin_s5.life_zero <= lz_s4;
			num_s5           <= num_s4;
			life_s5          <= life_s4;
		end
	end

	assign out_valid = valid_s5;
	assign out_kin   = kin_s5;
	assign out_num   = num_s5;
	assign out_life  = life_s5;

endmodule

// ----- sv/pua_div.sv -----
module pua_div #(
	parameter int SW = 9,
	parameter int PW = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_valid,
	input  logic [32+SW-1:0]      num,
	input  logic [31:0]           life,
	input  logic [PW-1:0]         pay,
	output logic                  out_valid,
	output logic [SW+pua_pkg::BLEND_BITS-1:0] quo,
	output logic [PW-1:0]         out_pay
);

	localparam int FB = pua_pkg::BLEND_BITS;
	localparam int QW = SW + FB;
	localparam int NW = 32 + SW;

	logic          vld_s [QW];
	logic          ovf_s [QW];
	logic [31:0]   rem_s [QW];
	logic [QW-1:0] q_s   [QW];
	logic [NW-1:0] num_s [QW];
	logic [31:0]   div_s [QW];
	logic [PW-1:0] pay_s [QW];

	// one quotient bit per stage, MSB first; dividend is num << FB
	for (genvar j = 0; j < QW; j++) begin : g_bit
		localparam int K = QW - 1 - j;
		logic          vld_in;
		logic          ovf_in;
		logic [31:0]   rem_in;
		logic [QW-1:0] q_in;
		logic [NW-1:0] num_in;
		logic [31:0]   div_in;
		logic [PW-1:0] pay_in;
		logic          dbit;
		logic [33:0]   diff;
		logic          ge;

		if (j == 0) begin : g_first
			assign vld_in = in_valid;
			assign rem_in = num[NW-1:SW];
			// quotient would not fit in QW bits
			assign ovf_in = rem_in >= div_in;
			assign q_in   = '0;
			assign num_in = num;
			assign div_in = life;
			assign pay_in = pay;
		end else begin : g_next
			assign vld_in = vld_s[j-1];
			assign ovf_in = ovf_s[j-1];
			assign rem_in = rem_s[j-1];
			assign q_in   = q_s[j-1];
			assign num_in = num_s[j-1];
			assign div_in = div_s[j-1];
			assign pay_in = pay_s[j-1];
		end

		if (K >= FB) begin : g_dbit
			assign dbit = num_in[K-FB];
		end else begin : g_zero
			assign dbit = 1'b0;
		end

		assign diff = {1'b0, rem_in, dbit} - {2'b00, div_in};
		assign ge   = !diff[33];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (adv) begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ovf_s[j] <= ovf_in;
				rem_s[j] <= ge ? diff[31:0] : {rem_in[30:0], dbit};
				q_s[j]   <= {q_in[QW-2:0], ge};
				num_s[j] <= num_in;
				div_s[j] <= div_in;
				pay_s[j] <= pay_in;
			end
		end
	end

	// an oversize quotient saturates, so the frame clamp always catches it
	assign out_valid = vld_s[QW-1];
	assign quo       = ovf_s[QW-1] ? '1 : q_s[QW-1];
	assign out_pay   = pay_s[QW-1];

endmodule

// ----- sv/pua_tex.sv -----
module pua_tex #(
	parameter int MAX_ROWS = pua_pkg::MAX_ROWS_DEF,
	parameter int RB       = 5,
	parameter int SW       = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_valid,
	input  logic [SW+pua_pkg::BLEND_BITS-1:0] quo,
	input  pua_pkg::kin_t         in_kin,
	input  logic [SW-1:0]         stages,
	input  logic [RB-1:0]         rows_eff,
	output logic                  out_valid,
	output pua_pkg::kin_t         out_kin,
	output logic [15:0]           blend,
	output logic [31:0]           tex_current,
	output logic [31:0]           tex_next
);

	localparam int FB  = pua_pkg::BLEND_BITS;
	localparam int QW  = SW + FB;
	localparam int XW  = SW + FB;
	localparam int K   = XW + RB;
	localparam int PRW = XW + K + 1;

	// ceil(2^K / rows): exact floor division by rows for any x below 2^XW
	logic [K:0] recip_tbl [MAX_ROWS+1];
	for (genvar g = 0; g <= MAX_ROWS; g++) begin : g_rcp
		localparam longint unsigned RV =
			(g == 0) ? 64'd0 : ((64'd1 << K) + 64'(g) - 64'd1) / 64'(g);
		assign recip_tbl[g] = RV[K:0];
	end

	logic [K:0] recip_q;

	logic [SW-1:0] idx_raw, last, idx1_c, idx2_c;
	logic [FB-1:0] blend_c;
	logic          clamp;

	logic          valid_s1, valid_s2, valid_s3, valid_s4;
	logic [SW-1:0] idx1_s1, idx2_s1, idx1_s2, idx2_s2, row1_s2, row2_s2;
	logic [SW-1:0] col1_s3, col2_s3, row1_s3, row2_s3;
	logic [FB-1:0] blend_s1, blend_s2, blend_s3, blend_s4;
	pua_pkg::kin_t kin_s1, kin_s2, kin_s3, kin_s4;
	logic [31:0]   texc_s4, texn_s4;

	logic [PRW-1:0] pr1, pr2, pu1, pv1, pu2, pv2;

	always_comb begin
		idx_raw = quo[QW-1:FB];
		last    = stages - SW'(1);
		clamp   = in_kin.life_zero || (idx_raw >= stages);
		idx1_c  = clamp ? last : idx_raw;
		blend_c = clamp ? '0 : quo[FB-1:0];
		idx2_c  = (idx1_c < last) ? idx1_c + SW'(1) : idx1_c;
	end

	assign pr1 = PRW'(idx1_s1) * PRW'(recip_q);
	assign pr2 = PRW'(idx2_s1) * PRW'(recip_q);
	assign pu1 = PRW'({col1_s3, {FB{1'b0}}}) * PRW'(recip_q);
	assign pv1 = PRW'({row1_s3, {FB{1'b0}}}) * PRW'(recip_q);
	assign pu2 = PRW'({col2_s3, {FB{1'b0}}}) * PRW'(recip_q);
	assign pv2 = PRW'({row2_s3, {FB{1'b0}}}) * PRW'(recip_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// rows are to change only while the pipe is empty; the core does not enforce this
	always_ff @(posedge clk) begin
		recip_q <= recip_tbl[rows_eff];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx1_s1  <= idx1_c;
			idx2_s1  <= idx2_c;
			blend_s1 <= blend_c;
			kin_s1   <= in_kin;

			row1_s2  <= SW'(pr1 >> K);
			row2_s2  <= SW'(pr2 >> K);
			idx1_s2  <= idx1_s1;
			idx2_s2  <= idx2_s1;
			blend_s2 <= blend_s1;
			kin_s2   <= kin_s1;

			col1_s3  <= idx1_s2 - SW'(row1_s2 * SW'(rows_eff));
			col2_s3  <= idx2_s2 - SW'(row2_s2 * SW'(rows_eff));
			row1_s3  <= row1_s2;
			row2_s3  <= row2_s2;
			blend_s3 <= blend_s2;
			kin_s3   <= kin_s2;

			kin_s4   <= kin_s3;
			if (kin_s3.dead) begin
				blend_s4 <= '0;
				texc_s4  <= '0;
				texn_s4  <= '0;
			end else begin
				blend_s4 <= blend_s3;
				texc_s4  <= {16'(pu1 >> K), 16'(pv1 >> K)};
				texn_s4  <= {16'(pu2 >> K), 16'(pv2 >> K)};
			end
		end
	end

	assign out_valid   = valid_s4;
	assign out_kin     = kin_s4;
	assign blend       = blend_s4;
	assign tex_current = texc_s4;
	assign tex_next    = texn_s4;

endmodule

// ----- sv/particle_update_atlas_frame_core.sv -----
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+------------------------------------------
// in        | in_valid / in_ready           | pos_*, vel_*, age, lifespan, gravity_factor
// out       | out_valid / out_ready         | new_pos_*, new_vel_*, new_age, expired,
//           |                               | blend, tex_current, tex_next
// cfg       | cfg_we (no back-pressure)     | cfg_index, cfg_wdata
//
// One transfer per cycle in and out while the pipe is not held. Items pass through
// the motion stages, the one-bit-per-stage frame divider and the atlas stages.
// Reset clears the stage valid bits and loads the register defaults.
// The whole pipe holds while a result waits on out_ready; nothing is dropped or
// repeated, and in_ready follows the same hold.
module particle_update_atlas_frame_core #(
	parameter int MAX_ROWS  = pua_pkg::MAX_ROWS_DEF,
	parameter int FRAC_BITS = pua_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_wdata,
	// particle in
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	input  logic [31:0]        age,
	input  logic [31:0]        lifespan,
	input  logic signed [31:0] gravity_factor,
	// particle out
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] new_pos_z,
	output logic signed [31:0] new_vel_x,
	output logic signed [31:0] new_vel_y,
	output logic signed [31:0] new_vel_z,
	output logic [31:0]        new_age,
	output logic               expired,
	output logic [15:0]        blend,
	output logic [31:0]        tex_current,
	output logic [31:0]        tex_next
);

	// rows width, frame-count width (holds rows^2 itself)
	localparam int RB = $clog2(MAX_ROWS + 1);
	localparam int SW = $clog2(MAX_ROWS * MAX_ROWS + 1);
	localparam int QW = SW + pua_pkg::BLEND_BITS;
	localparam int NW = 32 + SW;
	localparam int PW = $bits(pua_pkg::kin_t);

	logic [31:0]               dt_q;
	logic [pua_pkg::ROWS_W-1:0] rows_q;
	logic [RB-1:0]             rows_eff;
	logic [SW-1:0]             stages;

	logic                      adv;

	logic                      kin_valid;
	pua_pkg::kin_t             kin_out;
	logic [NW-1:0]             kin_num;
	logic [31:0]               kin_life;

	logic                      div_valid;
	logic [QW-1:0]             div_quo;
	logic [PW-1:0]             div_pay;

	pua_pkg::kin_t             res_kin;

	// global hold: advance unless a finished result is still waiting
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q   <= pua_pkg::DT_RESET;
			rows_q <= pua_pkg::ROWS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pua_pkg::REG_DELTA_TIME: begin
					dt_q <= cfg_wdata;
				end
				pua_pkg::REG_ATLAS_ROWS: begin
					rows_q <= cfg_wdata[pua_pkg::ROWS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// zero rows acts as one, oversize clamps to the largest atlas
	always_comb begin
		if (rows_q == '0) begin
			rows_eff = RB'(1);
		end else if (int'(rows_q) > MAX_ROWS) begin
			rows_eff = RB'(MAX_ROWS);
		end else begin
			rows_eff = RB'(rows_q);
		end
		stages = SW'(SW'(rows_eff) * SW'(rows_eff));
	end

	// motion, gravity, age and frame numerator
	pua_kin #(
		.FRAC_BITS (FRAC_BITS),
		.SW        (SW)
	) u_kin (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.in_valid       (in_valid),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z),
		.vel_x          (vel_x),
		.vel_y          (vel_y),
		.vel_z          (vel_z),
		.age            (age),
		.lifespan       (lifespan),
		.gravity_factor (gravity_factor),
		.dt             (dt_q),
		.stages         (stages),
		.out_valid      (kin_valid),
		.out_kin        (kin_out),
		.out_num        (kin_num),
		.out_life       (kin_life)
	);

	// (new_age * rows^2 << 16) / lifespan: frame index and blend in one quotient
	pua_div #(
		.SW (SW),
		.PW (PW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (kin_valid),
		.num       (kin_num),
		.life      (kin_life),
		.pay       (kin_out),
		.out_valid (div_valid),
		.quo       (div_quo),
		.out_pay   (div_pay)
	);

	// clamp, next frame, atlas offsets
	pua_tex #(
		.MAX_ROWS (MAX_ROWS),
		.RB       (RB),
		.SW       (SW)
	) u_tex (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (div_valid),
		.quo         (div_quo),
		.in_kin      (div_pay),
		.stages      (stages),
		.rows_eff    (rows_eff),
		.out_valid   (out_valid),
		.out_kin     (res_kin),
		.blend       (blend),
		.tex_current (tex_current),
		.tex_next    (tex_next)
	);

	assign new_pos_x = res_kin.pos_x;
	assign new_pos_y = res_kin.pos_y;
	assign new_pos_z = res_kin.pos_z;
	assign new_vel_x = res_kin.vel_x;
	assign new_vel_y = res_kin.vel_y;
	assign new_vel_z = res_kin.vel_z;
	assign new_age   = res_kin.age;
	assign expired   = res_kin.dead;

endmodule

// ----- sv/pua_chk.sv -----
module pua_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] new_pos_x,
	input logic        expired,
	input logic [15:0] blend,
	input logic [31:0] tex_current,
	input logic [31:0] tex_next
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(new_pos_x) && $stable(tex_current))
		else $error("stalled result changed");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready disagrees with output hold");

	a_dead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expired |-> blend == '0 && tex_current == '0 && tex_next == '0)
		else $error("expired particle carries atlas data");

endmodule

bind particle_update_atlas_frame_core pua_chk u_pua_chk (.*);
